// ===== rtl/core/stbs_pkg.sv =====
// shared types, codes and defaults for the sorted table binary search block
package stbs_pkg;

    // fixed field widths of the transaction payloads
    localparam int CFG_WIDTH   = 11;
    localparam int INDEX_WIDTH = 10;
    localparam int DATA_WIDTH  = 32;
    localparam int POS_WIDTH   = 10;

    // defaults for the top level parameters
    localparam int DEF_TABLE_DEPTH = 1024;
    localparam int DEF_VALUE_WIDTH = 32;

    // item kinds
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    typedef struct packed {
        logic                          command;
        logic [INDEX_WIDTH-1:0]        entry_index;
        logic signed [DATA_WIDTH-1:0]  data_value;
    } t_in_item;

    typedef struct packed {
        logic                  found;
        logic [POS_WIDTH-1:0]  match_position;
    } t_out_item;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_SEARCH
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic wr_en;    // store the input entry
        logic load;     // capture key and bounds, issue first probe
        logic advance;  // take the next bounds and probe
        logic finish;   // issue a result
        logic hit;      // result is a match
    } t_ctrl_cmd;

    // datapath to controller
    typedef struct packed {
        logic count_zero;
        logic probe_eq;
        logic range_empty;
    } t_dp_status;

endpackage

// ===== rtl/core/stbs_datapath.sv =====
// table memory, bounds registers, probe compare and result register
module stbs_datapath #(
    parameter int TABLE_DEPTH = stbs_pkg::DEF_TABLE_DEPTH,
    parameter int VALUE_WIDTH = stbs_pkg::DEF_VALUE_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  stbs_pkg::t_in_item            i_item,
    input  logic                          i_cfg_valid,
    input  logic [stbs_pkg::CFG_WIDTH-1:0] i_cfg_data,
    input  stbs_pkg::t_ctrl_cmd           i_cmd,
    output stbs_pkg::t_dp_status          o_status,
    output stbs_pkg::t_out_item           o_result,
    output logic                          o_done
);

    localparam int IW   = (TABLE_DEPTH > 2) ? $clog2(TABLE_DEPTH) : 1;
    localparam int BW   = IW + 2;
    localparam int EW   = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
    localparam int CMPW = (BW > stbs_pkg::CFG_WIDTH + 1) ? BW : stbs_pkg::CFG_WIDTH + 1;
    localparam int XW   = (IW + 1 > stbs_pkg::INDEX_WIDTH) ? IW + 1 : stbs_pkg::INDEX_WIDTH;

    logic [EW-1:0] r_mem [TABLE_DEPTH];
    logic [EW-1:0] r_rdata;

    logic [stbs_pkg::CFG_WIDTH-1:0] r_entries_in_use;
    logic [EW-1:0]                  r_key;
    logic signed [BW-1:0]           r_lo;
    logic signed [BW-1:0]           r_hi;
    logic [IW-1:0]                  r_mid;
    stbs_pkg::t_out_item            r_result;
    logic                           r_done;

    logic [CMPW-1:0]      cfg_ext;
    logic [CMPW-1:0]      count_sat;
    logic signed [BW-1:0] count_m1;
    logic [IW-1:0]        first_mid;
    logic [EW-1:0]        in_ordered;
    logic                 wr_in_range;
    logic [IW-1:0]        wr_addr;
    logic                 probe_lt;
    logic signed [BW-1:0] mid_ext;
    logic signed [BW-1:0] new_lo;
    logic signed [BW-1:0] new_hi;
    logic signed [BW-1:0] bound_sum;
    logic [IW-1:0]        new_mid;
    logic [IW-1:0]        rd_addr;

    // offset binary so that an unsigned compare follows signed order
    assign in_ordered = {~i_item.data_value[EW-1], i_item.data_value[EW-2:0]};

    assign cfg_ext   = CMPW'(r_entries_in_use);
    assign count_sat = (cfg_ext > CMPW'(TABLE_DEPTH)) ? CMPW'(TABLE_DEPTH) : cfg_ext;
    assign count_m1  = BW'(count_sat) - BW'(1);
    assign first_mid = count_m1[IW:1];

    assign wr_in_range = XW'(i_item.entry_index) < XW'(TABLE_DEPTH);
    assign wr_addr     = IW'(i_item.entry_index);

    assign probe_lt  = r_rdata < r_key;
    assign mid_ext   = $signed({2'b00, r_mid});
    assign new_lo    = probe_lt ? (mid_ext + BW'(1)) : r_lo;
    assign new_hi    = probe_lt ? r_hi : (mid_ext - BW'(1));
    assign bound_sum = new_lo + new_hi;
    assign new_mid   = bound_sum[IW:1];

    assign rd_addr = i_cmd.load ? first_mid : new_mid;

    assign o_status.count_zero  = (r_entries_in_use == '0);
    assign o_status.probe_eq    = (r_rdata == r_key);
    assign o_status.range_empty = (new_lo > new_hi);

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en && wr_in_range) begin
            r_mem[wr_addr] <= in_ordered;
        end
        r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key <= in_ordered;
            r_lo  <= '0;
            r_hi  <= count_m1;
            r_mid <= first_mid;
        end else if (i_cmd.advance) begin
            r_lo  <= new_lo;
            r_hi  <= new_hi;
            r_mid <= new_mid;
        end
        if (i_cmd.finish) begin
            r_result.found          <= i_cmd.hit;
            r_result.match_position <= i_cmd.hit ? stbs_pkg::POS_WIDTH'(r_mid) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries_in_use <= '0;
            r_done           <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_entries_in_use <= i_cfg_data;
            end
            r_done <= i_cmd.finish;
        end
    end

    assign o_result = r_result;
    assign o_done   = r_done;

endmodule

// ===== rtl/core/stbs_controller.sv =====
// search sequencer state machine
module stbs_controller (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_command,
    input  stbs_pkg::t_dp_status i_status,
    output stbs_pkg::t_ctrl_cmd  o_cmd,
    output logic                 o_busy
);

    stbs_pkg::t_state r_state;
    stbs_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= stbs_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b0;
        unique case (r_state)
            stbs_pkg::ST_IDLE: begin
                if (i_start) begin
                    if (i_command == stbs_pkg::CMD_WRITE) begin
                        o_cmd.wr_en = 1'b1;
                    end else if (i_status.count_zero) begin
                        // empty table: immediate miss
                        o_cmd.finish = 1'b1;
                    end else begin
                        o_cmd.load = 1'b1;
                        n_state    = stbs_pkg::ST_SEARCH;
                    end
                end
            end
            stbs_pkg::ST_SEARCH: begin
                o_busy = 1'b1;
                if (i_status.probe_eq) begin
                    o_cmd.finish = 1'b1;
                    o_cmd.hit    = 1'b1;
                    n_state      = stbs_pkg::ST_IDLE;
                end else if (i_status.range_empty) begin
                    o_cmd.finish = 1'b1;
                    n_state      = stbs_pkg::ST_IDLE;
                end else begin
                    o_cmd.advance = 1'b1;
                end
            end
            default: begin
                n_state = stbs_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/sorted_table_binary_search.sv =====
// top level of the sorted table binary search block
//
//  channel   ports                              transaction
//  -------   ---------------------------------  -------------------------------
//  item      start, busy, i_item                start high and busy low
//  result    o_result_strobe, o_result          strobe high, one cycle, no stall
//  config    i_cfg_valid, o_cfg_ready,          valid and ready high
//            i_cfg_data
//
//  a write item lands in the table at the accept edge
//  a search runs k probe rounds, at most floor(log2(count)) + 1, so 11 rounds
//    for a full 1024 entry table; one round per cycle is set by the single table
//    read port feeding the compare that picks the next probe
//  the result strobe comes the cycle after the last round, while busy is already low
//  synchronous active-low reset clears the state machine, the entry count
//    and the strobe; table contents are not cleared
//  the receiver cannot stall, so results never back up
module sorted_table_binary_search #(
    parameter int TABLE_DEPTH = stbs_pkg::DEF_TABLE_DEPTH,
    parameter int VALUE_WIDTH = stbs_pkg::DEF_VALUE_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // item transactions
    input  logic                           start,
    output logic                           busy,
    input  stbs_pkg::t_in_item             i_item,
    // result transactions
    output logic                           o_result_strobe,
    output stbs_pkg::t_out_item            o_result,
    // entry count register
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [stbs_pkg::CFG_WIDTH-1:0] i_cfg_data
);

    stbs_pkg::t_ctrl_cmd  ctrl_cmd;
    stbs_pkg::t_dp_status dp_status;

    // the count register takes a write in any cycle
    assign o_cfg_ready = 1'b1;

    // sequencer: idle accepts items, search runs one probe round per cycle
    stbs_controller u_controller (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_command (i_item.command),
        .i_status  (dp_status),
        .o_cmd     (ctrl_cmd),
        .o_busy    (busy)
    );

    // table memory, bounds, compare and registered result
    stbs_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (ctrl_cmd),
        .o_status    (dp_status),
        .o_result    (o_result),
        .o_done      (o_result_strobe)
    );

endmodule
